FILE: hdl/evr_pkg.sv
// Shared constants and the arctangent table for the Euler vector rotator.
package evr_pkg;

    // Rotation-mode CORDIC on a 32-bit phase, 30 micro-rotations
    localparam int CORDIC_STEPS = 30;
    // Datapath width of the CORDIC x/y/z registers (Q2.30 plus headroom)
    localparam int CW = 34;
    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032875;
    // Load stage, one stage per micro-rotation, round stage, clamp stage
    localparam int CORDIC_LAT = CORDIC_STEPS + 3;
    // Multiply stage, then sum/round/saturate stage
    localparam int PLANE_LAT = 2;

    // atan(2^-i) in units of 2^32 per turn
    function automatic logic signed [CW-1:0] atan_phase(input int idx);
        logic signed [CW-1:0] v;
        v = '0;
        unique case (idx)
            0:  v = 34'sd536870912;
            1:  v = 34'sd316933406;
            2:  v = 34'sd167458907;
            3:  v = 34'sd85004756;
            4:  v = 34'sd42667331;
            5:  v = 34'sd21354465;
            6:  v = 34'sd10679838;
            7:  v = 34'sd5340245;
            8:  v = 34'sd2670163;
            9:  v = 34'sd1335087;
            10: v = 34'sd667544;
            11: v = 34'sd333772;
            12: v = 34'sd166886;
            13: v = 34'sd83443;
            14: v = 34'sd41722;
            15: v = 34'sd20861;
            16: v = 34'sd10430;
            17: v = 34'sd5215;
            18: v = 34'sd2608;
            19: v = 34'sd1304;
            20: v = 34'sd652;
            21: v = 34'sd326;
            22: v = 34'sd163;
            23: v = 34'sd81;
            24: v = 34'sd41;
            25: v = 34'sd20;
            26: v = 34'sd10;
            27: v = 34'sd5;
            28: v = 34'sd3;
            29: v = 34'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

FILE: hdl/euler_vector_rotate_top.sv
// Euler yaw/pitch/roll rotator for a fixed-point 3D vector, top level.
//
// Request channel: req_valid/req_stall carry a Q16.16 vector and three binary
// angles (one full turn spans the whole angle range). Response channel:
// rsp_valid/rsp_stall carry the rotated, saturated vector and an overflow flag.
// A request is taken on a clock edge with valid high and stall low.
//
// Throughput: one request per cycle while the response channel is not stalled.
// The path runs through the 30-step sine/cosine pipeline (33 stages) followed by
// three planar rotations of 2 stages each (multiply, then round/saturate).
//
// All stages advance together. While rsp_valid is high and rsp_stall is high
// the whole pipeline holds and req_stall is raised; nothing is dropped or
// repeated. Empty slots further back in the pipeline do not let it move.
//
// Reset (rst_n low, asynchronous) clears every valid bit; in-flight requests
// are discarded. Data registers are not reset.
module euler_vector_rotate_top #(
    parameter int VEC_BITS   = 32,
    parameter int ANGLE_BITS = 16,
    parameter int COEF_BITS  = 18
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       req_valid,
    output logic                       req_stall,
    input  logic signed [VEC_BITS-1:0] vec_x,
    input  logic signed [VEC_BITS-1:0] vec_y,
    input  logic signed [VEC_BITS-1:0] vec_z,
    input  logic [ANGLE_BITS-1:0]      yaw_angle,
    input  logic [ANGLE_BITS-1:0]      pitch_angle,
    input  logic [ANGLE_BITS-1:0]      roll_angle,
    output logic                       rsp_valid,
    input  logic                       rsp_stall,
    output logic signed [VEC_BITS-1:0] rot_x,
    output logic signed [VEC_BITS-1:0] rot_y,
    output logic signed [VEC_BITS-1:0] rot_z,
    output logic                       overflowed
);
    import evr_pkg::*;

    localparam int LAT = CORDIC_LAT + 3 * PLANE_LAT;

    logic en;
    logic vld_reg [0:LAT-1];
    logic signed [VEC_BITS-1:0] vx_reg [0:CORDIC_LAT-1];
    logic signed [VEC_BITS-1:0] vy_reg [0:CORDIC_LAT-1];
    logic signed [VEC_BITS-1:0] vz_reg [0:CORDIC_LAT-1];
    logic signed [COEF_BITS-1:0] pc_reg [0:PLANE_LAT-1];
    logic signed [COEF_BITS-1:0] ps_reg [0:PLANE_LAT-1];
    logic signed [COEF_BITS-1:0] rc_reg [0:2*PLANE_LAT-1];
    logic signed [COEF_BITS-1:0] rs_reg [0:2*PLANE_LAT-1];

    logic signed [COEF_BITS-1:0] yc, ys, pc, ps, rc, rs;
    logic signed [VEC_BITS-1:0]  x1, z1, y1p, y2, z2, x2p, x3, y3, z3p;
    logic                        ov1, ov2, ov3;

    // Global advance: hold everything only when the output is full and stalled
    assign en        = !(vld_reg[LAT-1] && rsp_stall);
    assign req_stall = !en;

    // Valid bits travel alongside the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < LAT; k++)
                vld_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= req_valid;
            for (int k = 1; k < LAT; k++)
                vld_reg[k] <= vld_reg[k-1];
        end
    end

    // Vector waits in a delay line while the coefficients are computed
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vx_reg[0] <= vec_x;
            vy_reg[0] <= vec_y;
            vz_reg[0] <= vec_z;
            for (int k = 1; k < CORDIC_LAT; k++)
            begin
                vx_reg[k] <= vx_reg[k-1];
                vy_reg[k] <= vy_reg[k-1];
                vz_reg[k] <= vz_reg[k-1];
            end
        end
    end

    evr_cordic #(.ANGLE_BITS(ANGLE_BITS), .COEF_BITS(COEF_BITS)) u_cordic_yaw (
        .clk(clk), .en(en), .ang(yaw_angle), .cos_c(yc), .sin_c(ys)
    );
    evr_cordic #(.ANGLE_BITS(ANGLE_BITS), .COEF_BITS(COEF_BITS)) u_cordic_pitch (
        .clk(clk), .en(en), .ang(pitch_angle), .cos_c(pc), .sin_c(ps)
    );
    evr_cordic #(.ANGLE_BITS(ANGLE_BITS), .COEF_BITS(COEF_BITS)) u_cordic_roll (
        .clk(clk), .en(en), .ang(roll_angle), .cos_c(rc), .sin_c(rs)
    );

    // Align pitch and roll coefficients with their rotation stage
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pc_reg[0] <= pc;
            ps_reg[0] <= ps;
            for (int k = 1; k < PLANE_LAT; k++)
            begin
                pc_reg[k] <= pc_reg[k-1];
                ps_reg[k] <= ps_reg[k-1];
            end
            rc_reg[0] <= rc;
            rs_reg[0] <= rs;
            for (int k = 1; k < 2 * PLANE_LAT; k++)
            begin
                rc_reg[k] <= rc_reg[k-1];
                rs_reg[k] <= rs_reg[k-1];
            end
        end
    end

    // Yaw in x/z
    evr_plane #(.VEC_BITS(VEC_BITS), .COEF_BITS(COEF_BITS)) u_yaw (
        .clk(clk), .en(en),
        .a(vx_reg[CORDIC_LAT-1]), .b(vz_reg[CORDIC_LAT-1]),
        .pass(vy_reg[CORDIC_LAT-1]), .ovf_in(1'b0),
        .cos_c(yc), .sin_c(ys),
        .na(x1), .nb(z1), .pass_out(y1p), .ovf_out(ov1)
    );

    // Pitch in y/z
    evr_plane #(.VEC_BITS(VEC_BITS), .COEF_BITS(COEF_BITS)) u_pitch (
        .clk(clk), .en(en),
        .a(y1p), .b(z1), .pass(x1), .ovf_in(ov1),
        .cos_c(pc_reg[PLANE_LAT-1]), .sin_c(ps_reg[PLANE_LAT-1]),
        .na(y2), .nb(z2), .pass_out(x2p), .ovf_out(ov2)
    );

    // Roll in x/y; its last stage is the output register
    evr_plane #(.VEC_BITS(VEC_BITS), .COEF_BITS(COEF_BITS)) u_roll (
        .clk(clk), .en(en),
        .a(x2p), .b(y2), .pass(z2), .ovf_in(ov2),
        .cos_c(rc_reg[2*PLANE_LAT-1]), .sin_c(rs_reg[2*PLANE_LAT-1]),
        .na(x3), .nb(y3), .pass_out(z3p), .ovf_out(ov3)
    );

    assign rsp_valid  = vld_reg[LAT-1];
    assign rot_x      = x3;
    assign rot_y      = y3;
    assign rot_z      = z3p;
    assign overflowed = ov3;

endmodule

FILE: hdl/evr_cordic.sv
// Pipelined CORDIC: binary angle to clamped Q2.(COEF_BITS-2) cosine and sine.
module evr_cordic #(
    parameter int ANGLE_BITS = 16,
    parameter int COEF_BITS  = 18
) (
    input  logic                        clk,
    input  logic                        en,
    input  logic [ANGLE_BITS-1:0]       ang,
    output logic signed [COEF_BITS-1:0] cos_c,
    output logic signed [COEF_BITS-1:0] sin_c
);
    import evr_pkg::*;

    localparam int FRAC = COEF_BITS - 2;
    localparam int RSH  = 30 - FRAC;

    logic signed [CW-1:0] x_reg [0:CORDIC_STEPS];
    logic signed [CW-1:0] y_reg [0:CORDIC_STEPS];
    logic signed [CW-1:0] z_reg [0:CORDIC_STEPS];
    logic                 flip_reg [0:CORDIC_STEPS];
    logic signed [CW-1:0] xr_reg, yr_reg;
    logic                 flipr_reg;
    logic signed [COEF_BITS-1:0] c_reg, s_reg;

    logic [31:0]          phase;
    logic                 flip_next;
    logic [31:0]          phase_adj;
    logic signed [CW-1:0] half;
    logic signed [CW-1:0] one;
    logic signed [CW-1:0] xr_next, yr_next;
    logic signed [CW-1:0] xc, yc;

    // Left-align the angle, fold the outer half-turn onto [-90, 90) degrees
    always_comb
    begin
        phase     = {ang, {(32-ANGLE_BITS){1'b0}}};
        flip_next = phase[31] ^ phase[30];
        phase_adj = {phase[31] ^ flip_next, phase[30:0]};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= CORDIC_GAIN;
            y_reg[0]    <= '0;
            z_reg[0]    <= CW'(signed'(phase_adj));
            flip_reg[0] <= flip_next;
        end
    end

    // One micro-rotation per stage
    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_step
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (z_reg[i] >= 0)
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - atan_phase(i);
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + atan_phase(i);
                end
                flip_reg[i+1] <= flip_reg[i];
            end
        end
    end

    // Round half up to the coefficient format
    always_comb
    begin
        half    = CW'(1) <<< (RSH - 1);
        xr_next = (x_reg[CORDIC_STEPS] + half) >>> RSH;
        yr_next = (y_reg[CORDIC_STEPS] + half) >>> RSH;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xr_reg    <= xr_next;
            yr_reg    <= yr_next;
            flipr_reg <= flip_reg[CORDIC_STEPS];
        end
    end

    // Clamp to +/-1.0, then undo the half-turn fold
    always_comb
    begin
        one = CW'(1) <<< FRAC;
        xc  = xr_reg;
        yc  = yr_reg;
        if (xc > one)  xc = one;
        if (xc < -one) xc = -one;
        if (yc > one)  yc = one;
        if (yc < -one) yc = -one;
        if (flipr_reg)
        begin
            xc = -xc;
            yc = -yc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_reg <= xc[COEF_BITS-1:0];
            s_reg <= yc[COEF_BITS-1:0];
        end
    end

    assign cos_c = c_reg;
    assign sin_c = s_reg;

endmodule

FILE: hdl/evr_plane.sv
// Two-stage planar rotation with rounding and saturation.
module evr_plane #(
    parameter int VEC_BITS  = 32,
    parameter int COEF_BITS = 18
) (
    input  logic                        clk,
    input  logic                        en,
    input  logic signed [VEC_BITS-1:0]  a,
    input  logic signed [VEC_BITS-1:0]  b,
    input  logic signed [VEC_BITS-1:0]  pass,
    input  logic                        ovf_in,
    input  logic signed [COEF_BITS-1:0] cos_c,
    input  logic signed [COEF_BITS-1:0] sin_c,
    output logic signed [VEC_BITS-1:0]  na,
    output logic signed [VEC_BITS-1:0]  nb,
    output logic signed [VEC_BITS-1:0]  pass_out,
    output logic                        ovf_out
);
    import evr_pkg::*;

    localparam int FRAC = COEF_BITS - 2;
    localparam int PW   = COEF_BITS + VEC_BITS;
    localparam int SW   = PW + 1;

    logic signed [PW-1:0]       ca_reg, sb_reg, nsa_reg, cb_reg;
    logic signed [VEC_BITS-1:0] pass1_reg, pass2_reg;
    logic                       ovf1_reg, ovf2_reg;
    logic signed [VEC_BITS-1:0] na_reg, nb_reg;

    logic signed [COEF_BITS-1:0] nsin;
    logic signed [SW-1:0]        half;
    logic signed [SW-1:0]        suma, sumb;
    logic signed [SW-1:0]        sha, shb;
    logic signed [VEC_BITS-1:0]  sata, satb;
    logic                        ova, ovb;

    assign nsin = -sin_c;

    // Stage 1: the four products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ca_reg    <= PW'(cos_c) * PW'(a);
            sb_reg    <= PW'(sin_c) * PW'(b);
            nsa_reg   <= PW'(nsin) * PW'(a);
            cb_reg    <= PW'(cos_c) * PW'(b);
            pass1_reg <= pass;
            ovf1_reg  <= ovf_in;
        end
    end

    // Stage 2: exact sum, round half up, saturate
    always_comb
    begin
        half = SW'(1) <<< (FRAC - 1);
        suma = SW'(ca_reg) + SW'(sb_reg) + half;
        sumb = SW'(nsa_reg) + SW'(cb_reg) + half;
        sha  = suma >>> FRAC;
        shb  = sumb >>> FRAC;
        ova  = !((&sha[SW-1:VEC_BITS-1]) || !(|sha[SW-1:VEC_BITS-1]));
        ovb  = !((&shb[SW-1:VEC_BITS-1]) || !(|shb[SW-1:VEC_BITS-1]));
        if (ova)
            sata = sha[SW-1] ? {1'b1, {(VEC_BITS-1){1'b0}}} : {1'b0, {(VEC_BITS-1){1'b1}}};
        else
            sata = sha[VEC_BITS-1:0];
        if (ovb)
            satb = shb[SW-1] ? {1'b1, {(VEC_BITS-1){1'b0}}} : {1'b0, {(VEC_BITS-1){1'b1}}};
        else
            satb = shb[VEC_BITS-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            na_reg    <= sata;
            nb_reg    <= satb;
            pass2_reg <= pass1_reg;
            ovf2_reg  <= ovf1_reg | ova | ovb;
        end
    end

    assign na       = na_reg;
    assign nb       = nb_reg;
    assign pass_out = pass2_reg;
    assign ovf_out  = ovf2_reg;

endmodule
